// File: hdl/tpf_pkg.sv
// Shared types, codes and constants of the timestamped packet FIFO.
package tpf_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int TS_W            = 48;
    localparam int SIZE_W          = 24;
    localparam int TAG_W           = 16;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              has_ts;
        logic [TS_W-1:0]   ts;
        logic [SIZE_W-1:0] size;
        logic              ordered;
    } t_entry;

    typedef struct packed {
        logic entry;
        logic ordered;
    } t_mem_wen;

    // Signed timestamp order mapped onto unsigned order.
    function automatic logic [TS_W-1:0] order_key(input logic [TS_W-1:0] ts);
        return {~ts[TS_W-1], ts[TS_W-2:0]};
    endfunction

endpackage

// File: hdl/tpf_mem.sv
// Descriptor store and in-order timestamp store, with registered reads.
module tpf_mem
    import tpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH)
) (
    input  logic            i_clk,
    input  t_mem_wen        i_wen,
    input  logic [AW-1:0]   i_entry_waddr,
    input  t_entry          i_entry_wdata,
    input  logic [AW-1:0]   i_entry_raddr,
    output t_entry          o_entry_rdata,
    input  logic [AW-1:0]   i_ord_waddr,
    input  logic [TS_W-1:0] i_ord_wdata,
    input  logic [AW-1:0]   i_ord_raddr,
    output logic [TS_W-1:0] o_ord_rdata
);

    t_entry          entry_mem [QUEUE_DEPTH];
    logic [TS_W-1:0] ord_mem   [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen.entry) begin
            entry_mem[i_entry_waddr] <= i_entry_wdata;
        end
        o_entry_rdata <= entry_mem[i_entry_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wen.ordered) begin
            ord_mem[i_ord_waddr] <= i_ord_wdata;
        end
        o_ord_rdata <= ord_mem[i_ord_raddr];
    end

endmodule

// File: hdl/timestamped_packet_fifo.sv
// Top level of the timestamped packet FIFO: sequencer, counters and result register.
//
// Input channel: i_valid / o_stall with opcode (push, pop, clear), timestamp flag,
// timestamp, byte size and tag. Output channel: o_valid / i_stall, one result per
// transfer in: status, popped descriptor, occupancy, byte total and the span between
// the oldest and newest in-order timestamps held.
// A transfer is taken when valid is high and stall is low at a rising edge.
//
// One item at a time. Push, clear, no-op and pop-from-empty results pass through S_REPORT
// into the result register; any other pop first passes through S_POP_RD, and also through
// S_FIRST when the popped packet was in order and the in-order subqueue is left non-empty
// (second read, of the next oldest in-order timestamp). A new item is taken in the cycle
// after the result is loaded.
//
// Reset (synchronous, active low) empties the queue and forgets the last in-order
// time; memory contents are not cleared and need no clearing pass. While the
// receiver stalls, the result register holds; one more item is taken and processed,
// then the block stops taking items until the held result is transferred.
module timestamped_packet_fifo
    import tpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic              i_has_timestamp,
    input  logic [TS_W-1:0]   i_timestamp,
    input  logic [SIZE_W-1:0] i_byte_size,
    input  logic [TAG_W-1:0]  i_packet_tag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [TAG_W-1:0]  o_popped_tag,
    output logic              o_popped_has_timestamp,
    output logic [TS_W-1:0]   o_popped_timestamp,
    output logic [SIZE_W-1:0] o_popped_size,
    output logic              o_queue_empty,
    output logic [8:0]        o_entry_count,
    output logic [31:0]       o_queued_bytes,
    output logic [TS_W-1:0]   o_span_duration
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = SIZE_W + CW;
    localparam int SW = (BW > 32) ? BW : 32;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP_RD = 2'd1;
    localparam logic [1:0] S_FIRST  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_head, n_head, r_tail, n_tail, r_ohead, n_ohead;
    logic [CW-1:0]     r_count, n_count, r_ocount, n_ocount;
    logic [BW-1:0]     r_bytes, n_bytes;
    logic [TS_W-1:0]   r_last, n_last, r_first, n_first;
    logic              r_last_valid, n_last_valid;

    logic [1:0]        r_status, n_status;
    logic [TAG_W-1:0]  r_pop_tag, n_pop_tag;
    logic              r_pop_has, n_pop_has;
    logic [TS_W-1:0]   r_pop_ts, n_pop_ts;
    logic [SIZE_W-1:0] r_pop_size, n_pop_size;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic [TAG_W-1:0]  r_out_tag, n_out_tag;
    logic              r_out_has, n_out_has;
    logic [TS_W-1:0]   r_out_ts, n_out_ts;
    logic [SIZE_W-1:0] r_out_size, n_out_size;
    logic              r_out_empty, n_out_empty;
    logic [8:0]        r_out_count, n_out_count;
    logic [31:0]       r_out_bytes, n_out_bytes;
    logic [TS_W-1:0]   r_out_span, n_out_span;

    t_mem_wen          mem_wen;
    t_entry            entry_wdata, entry_rdata;
    logic [AW-1:0]     ord_waddr, ord_raddr;
    logic [TS_W-1:0]   ord_rdata;

    logic              in_xfer, out_free, joins;
    logic [CW:0]       ord_slot;
    logic [SW-1:0]     bytes_ext;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == AW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign joins = i_has_timestamp &&
                   (!r_last_valid || (order_key(i_timestamp) >= order_key(r_last)));

    // Tail of the in-order subqueue; the sum stays below twice the depth.
    always_comb begin
        ord_slot = (CW + 1)'(r_ohead) + (CW + 1)'(r_ocount);
        if (ord_slot >= (CW + 1)'(QUEUE_DEPTH)) begin
            ord_slot = ord_slot - (CW + 1)'(QUEUE_DEPTH);
        end
    end
    assign ord_waddr = ord_slot[AW-1:0];

    assign entry_wdata = '{tag: i_packet_tag, has_ts: i_has_timestamp, ts: i_timestamp,
                           size: i_byte_size, ordered: joins};

    assign bytes_ext = SW'(r_bytes);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ohead      = r_ohead;
        n_count      = r_count;
        n_ocount     = r_ocount;
        n_bytes      = r_bytes;
        n_last       = r_last;
        n_first      = r_first;
        n_last_valid = r_last_valid;
        n_status     = r_status;
        n_pop_tag    = r_pop_tag;
        n_pop_has    = r_pop_has;
        n_pop_ts     = r_pop_ts;
        n_pop_size   = r_pop_size;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_has    = r_out_has;
        n_out_ts     = r_out_ts;
        n_out_size   = r_out_size;
        n_out_empty  = r_out_empty;
        n_out_count  = r_out_count;
        n_out_bytes  = r_out_bytes;
        n_out_span   = r_out_span;
        mem_wen      = '0;
        ord_raddr    = r_ohead;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_status   = ST_OK;
                    n_pop_tag  = '0;
                    n_pop_has  = 1'b0;
                    n_pop_ts   = '0;
                    n_pop_size = '0;
                    n_state    = S_REPORT;
                    case (i_opcode)
                        OP_PUSH: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                mem_wen.entry = 1'b1;
                                n_tail  = wrap_inc(r_tail);
                                n_count = r_count + 1'b1;
                                n_bytes = r_bytes + BW'(i_byte_size);
                                if (joins) begin
                                    mem_wen.ordered = 1'b1;
                                    n_last       = i_timestamp;
                                    n_last_valid = 1'b1;
                                    n_ocount     = r_ocount + 1'b1;
                                    if (r_ocount == '0) begin
                                        n_first = i_timestamp;
                                    end
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_head       = '0;
                            n_tail       = '0;
                            n_ohead      = '0;
                            n_count      = '0;
                            n_ocount     = '0;
                            n_bytes      = '0;
                            n_last       = '0;
                            n_last_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_pop_tag  = entry_rdata.tag;
                n_pop_has  = entry_rdata.has_ts;
                n_pop_ts   = entry_rdata.ts;
                n_pop_size = entry_rdata.size;
                n_head     = wrap_inc(r_head);
                n_count    = r_count - 1'b1;
                n_bytes    = (r_bytes >= BW'(entry_rdata.size)) ?
                             r_bytes - BW'(entry_rdata.size) : '0;
                n_state    = S_REPORT;
                if (entry_rdata.ordered && (r_ocount != '0)) begin
                    n_ohead   = wrap_inc(r_ohead);
                    n_ocount  = r_ocount - 1'b1;
                    ord_raddr = n_ohead;
                    if (n_ocount != '0) begin
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                n_first = ord_rdata;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_tag    = r_pop_tag;
                    n_out_has    = r_pop_has;
                    n_out_ts     = r_pop_ts;
                    n_out_size   = r_pop_size;
                    n_out_empty  = (r_count == '0);
                    n_out_count  = 9'(r_count);
                    n_out_bytes  = (bytes_ext > SW'(32'hFFFF_FFFF)) ? '1 : bytes_ext[31:0];
                    n_out_span   = (r_ocount >= CW'(2)) ? r_last - r_first : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_ohead      <= '0;
            r_count      <= '0;
            r_ocount     <= '0;
            r_bytes      <= '0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_ohead      <= n_ohead;
            r_count      <= n_count;
            r_ocount     <= n_ocount;
            r_bytes      <= n_bytes;
            r_last       <= n_last;
            r_last_valid <= n_last_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first      <= n_first;
        r_status     <= n_status;
        r_pop_tag    <= n_pop_tag;
        r_pop_has    <= n_pop_has;
        r_pop_ts     <= n_pop_ts;
        r_pop_size   <= n_pop_size;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
        r_out_has    <= n_out_has;
        r_out_ts     <= n_out_ts;
        r_out_size   <= n_out_size;
        r_out_empty  <= n_out_empty;
        r_out_count  <= n_out_count;
        r_out_bytes  <= n_out_bytes;
        r_out_span   <= n_out_span;
    end

    tpf_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk         (i_clk),
        .i_wen         (mem_wen),
        .i_entry_waddr (r_tail),
        .i_entry_wdata (entry_wdata),
        .i_entry_raddr (r_head),
        .o_entry_rdata (entry_rdata),
        .i_ord_waddr   (ord_waddr),
        .i_ord_wdata   (i_timestamp),
        .i_ord_raddr   (ord_raddr),
        .o_ord_rdata   (ord_rdata)
    );

    assign o_valid                = r_out_valid;
    assign o_status               = r_out_status;
    assign o_popped_tag           = r_out_tag;
    assign o_popped_has_timestamp = r_out_has;
    assign o_popped_timestamp     = r_out_ts;
    assign o_popped_size          = r_out_size;
    assign o_queue_empty          = r_out_empty;
    assign o_entry_count          = r_out_count;
    assign o_queued_bytes         = r_out_bytes;
    assign o_span_duration        = r_out_span;

endmodule

// File: hdl/tpf_checker.sv
// Port-level assertions for the timestamped packet FIFO, bound to the top level.
module tpf_checker
    import tpf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic [TAG_W-1:0]  o_popped_tag,
    input logic              o_popped_has_timestamp,
    input logic [TS_W-1:0]   o_popped_timestamp,
    input logic [SIZE_W-1:0] o_popped_size,
    input logic              o_queue_empty,
    input logic [8:0]        o_entry_count,
    input logic [31:0]       o_queued_bytes,
    input logic [TS_W-1:0]   o_span_duration
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_popped_tag)
            && $stable(o_entry_count) && $stable(o_span_duration))
        else $error("result changed under stall");

    // One item at a time: the cycle after a transfer in, the input is stalled.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while an item is in progress");

    // Empty queue holds no bytes and no span.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_queue_empty |-> o_queued_bytes == '0 && o_span_duration == '0)
        else $error("empty queue reports bytes or span");

    // A pop from an empty queue returns no descriptor.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_POP_EMPTY |-> o_queue_empty && o_popped_tag == '0
            && o_popped_size == '0 && !o_popped_has_timestamp
            && o_popped_timestamp == '0)
        else $error("bad result for pop from empty queue");

endmodule

bind timestamped_packet_fifo tpf_checker u_tpf_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the timestamped packet FIFO: directed and random traffic.
module tb_top
    import tpf_pkg::*;
();

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, must behave as a no-op
    localparam logic [TS_W-1:0] TS_MIN = {1'b1, {(TS_W-1){1'b0}}};
    localparam logic [TS_W-1:0] TS_MAX = {1'b0, {(TS_W-1){1'b1}}};
    localparam int RANDOM_ITEMS = 1300;
    localparam int PRESSURE_ITEMS = 40;
    localparam int PRESSURE_HOLD = 400;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  tag;
        logic              has_ts;
        logic [TS_W-1:0]   ts;
        logic [SIZE_W-1:0] size;
        logic              empty;
        logic [8:0]        count;
        logic [31:0]       bytes;
        logic [TS_W-1:0]   span;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_opcode;
    logic              i_has_timestamp;
    logic [TS_W-1:0]   i_timestamp;
    logic [SIZE_W-1:0] i_byte_size;
    logic [TAG_W-1:0]  i_packet_tag;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_status;
    logic [TAG_W-1:0]  o_popped_tag;
    logic              o_popped_has_timestamp;
    logic [TS_W-1:0]   o_popped_timestamp;
    logic [SIZE_W-1:0] o_popped_size;
    logic              o_queue_empty;
    logic [8:0]        o_entry_count;
    logic [31:0]       o_queued_bytes;
    logic [TS_W-1:0]   o_span_duration;

    timestamped_packet_fifo dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_opcode               (i_opcode),
        .i_has_timestamp        (i_has_timestamp),
        .i_timestamp            (i_timestamp),
        .i_byte_size            (i_byte_size),
        .i_packet_tag           (i_packet_tag),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_status               (o_status),
        .o_popped_tag           (o_popped_tag),
        .o_popped_has_timestamp (o_popped_has_timestamp),
        .o_popped_timestamp     (o_popped_timestamp),
        .o_popped_size          (o_popped_size),
        .o_queue_empty          (o_queue_empty),
        .o_entry_count          (o_entry_count),
        .o_queued_bytes         (o_queued_bytes),
        .o_span_duration        (o_span_duration)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the queue
    t_entry            shadow_slot [DEPTH];
    logic [TS_W-1:0]   shadow_ordered [DEPTH];
    int unsigned       shadow_head, shadow_tail, shadow_count;
    int unsigned       shadow_ord_head, shadow_ord_count;
    longint unsigned   shadow_bytes;
    logic [TS_W-1:0]   shadow_last_ts;
    logic              shadow_last_valid;

    // Expected results in transfer order; at most two are ever outstanding
    t_result           exp_ring [EXP_DEPTH];
    int unsigned       exp_wr = 0;
    int unsigned       exp_rd = 0;
    int                errors = 0;
    bit                tx_idle = 1'b1;
    bit                rx_idle = 1'b1;
    bit                rx_took = 1'b0;
    int                rx_wait = 0;
    int                press_hold = 0;
    logic [TS_W-1:0]   ts_cursor = '0;

    function automatic void clear_shadow();
        shadow_head       = 0;
        shadow_tail       = 0;
        shadow_count      = 0;
        shadow_ord_head   = 0;
        shadow_ord_count  = 0;
        shadow_bytes      = 0;
        shadow_last_ts    = '0;
        shadow_last_valid = 1'b0;
    endfunction

    function automatic t_result predict_fifo_result(input logic [1:0] op, input logic has_ts,
            input logic [TS_W-1:0] ts, input logic [SIZE_W-1:0] size,
            input logic [TAG_W-1:0] tag);
        t_result         r;
        t_entry          e;
        logic [TS_W-1:0] first_ts;
        logic [TS_W-1:0] newest_ts;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    e.tag     = tag;
                    e.has_ts  = has_ts;
                    e.ts      = ts;
                    e.size    = size;
                    e.ordered = 1'b0;
                    // joins the in-order run if not below the last in-order time (signed)
                    if (has_ts && (!shadow_last_valid ||
                            $signed(ts) >= $signed(shadow_last_ts))) begin
                        e.ordered         = 1'b1;
                        shadow_last_ts    = ts;
                        shadow_last_valid = 1'b1;
                        shadow_ordered[(shadow_ord_head + shadow_ord_count) % DEPTH] = ts;
                        shadow_ord_count++;
                    end
                    shadow_slot[shadow_tail] = e;
                    shadow_tail  = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                    shadow_bytes += size;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    e        = shadow_slot[shadow_head];
                    r.tag    = e.tag;
                    r.has_ts = e.has_ts;
                    r.ts     = e.ts;
                    r.size   = e.size;
                    if (e.ordered && shadow_ord_count > 0) begin
                        shadow_ord_head = (shadow_ord_head + 1) % DEPTH;
                        shadow_ord_count--;
                    end
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                    shadow_bytes = (shadow_bytes >= e.size) ? shadow_bytes - e.size : 0;
                end
            end
            OP_CLEAR: clear_shadow();
            default: ;
        endcase
        r.empty = (shadow_count == 0);
        r.count = 9'(shadow_count);
        r.bytes = (shadow_bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(shadow_bytes);
        if (shadow_ord_count >= 2) begin
            first_ts  = shadow_ordered[shadow_ord_head];
            newest_ts = shadow_ordered[(shadow_ord_head + shadow_ord_count - 1) % DEPTH];
            r.span    = newest_ts - first_ts;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        if (errors < 200)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Sends one item; valid stays high when the next item follows without a gap
    task automatic send_op(input logic [1:0] op, input logic has_ts, input logic [TS_W-1:0] ts,
            input logic [SIZE_W-1:0] size, input logic [TAG_W-1:0] tag);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode        <= op;
        i_has_timestamp <= has_ts;
        i_timestamp     <= ts;
        i_byte_size     <= size;
        i_packet_tag    <= tag;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        exp_ring[exp_wr % EXP_DEPTH] = predict_fifo_result(op, has_ts, ts, size, tag);
        exp_wr++;
    endtask

    task automatic send_random_op(input int push_permille);
        int              pick;
        int              op_pick;
        logic [1:0]      op;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            ts_cursor = ts_cursor + $urandom_range(0, 5000);
        else if (pick < 70)
            ts_cursor = ts_cursor;
        else if (pick < 80)
            ts_cursor = ts_cursor - $urandom_range(1, 5000);
        else if (pick < 95)
            ts_cursor = TS_W'({$urandom(), $urandom()});
        else
            ts_cursor = pick[0] ? TS_MAX - $urandom_range(0, 3000)
                                : TS_MIN + $urandom_range(0, 3000);
        size    = $urandom_range(0, 1) ? SIZE_W'($urandom()) : SIZE_W'($urandom_range(0, 4000));
        op_pick = $urandom_range(0, 999);
        if (op_pick < 8)
            op = OP_CLEAR;
        else if (op_pick < 16)
            op = OP_NONE;
        else if (op_pick < 16 + push_permille)
            op = OP_PUSH;
        else
            op = OP_POP;
        send_op(op, $urandom_range(0, 99) < 80, ts_cursor, size, TAG_W'($urandom()));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            rx_took = 1'b1;
            got = {o_status, o_popped_tag, o_popped_has_timestamp, o_popped_timestamp,
                   o_popped_size, o_queue_empty, o_entry_count, o_queued_bytes,
                   o_span_duration};
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected result, status", 64'(got.status), 64'(0));
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.tag !== want.tag)
                    report_mismatch("popped_tag", 64'(got.tag), 64'(want.tag));
                if (got.has_ts !== want.has_ts)
                    report_mismatch("popped_has_timestamp", 64'(got.has_ts),
                                    64'(want.has_ts));
                if (got.ts !== want.ts)
                    report_mismatch("popped_timestamp", 64'(got.ts), 64'(want.ts));
                if (got.size !== want.size)
                    report_mismatch("popped_size", 64'(got.size), 64'(want.size));
                if (got.empty !== want.empty)
                    report_mismatch("queue_empty", 64'(got.empty), 64'(want.empty));
                if (got.count !== want.count)
                    report_mismatch("entry_count", 64'(got.count), 64'(want.count));
                if (got.bytes !== want.bytes)
                    report_mismatch("queued_bytes", 64'(got.bytes), 64'(want.bytes));
                if (got.span !== want.span)
                    report_mismatch("span_duration", 64'(got.span), 64'(want.span));
            end
        end
    end

    // Receiver: a fresh wait is drawn after each transfer out; a long hold overrides it
    always @(negedge i_clk) begin
        if (rx_took) begin
            rx_took = 1'b0;
            rx_wait = rx_idle ? $urandom_range(0, 17) : 0;
        end
        if (press_hold > 0) begin
            press_hold--;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic test_directed_ops();
        send_op(OP_POP,   1'b0, '0,      '0,          '0);        // pop from empty
        send_op(OP_NONE,  1'b1, TS_MAX,  24'hFFFFFF,  16'hFFFF);
        send_op(OP_PUSH,  1'b1, TS_MAX,  24'hFFFFFF,  16'hFFFF);  // first stamp always joins
        send_op(OP_PUSH,  1'b1, TS_MIN,  24'h000000,  16'h0000);  // below last, not in order
        send_op(OP_PUSH,  1'b0, '1,      24'h000001,  16'h0001);  // no timestamp
        send_op(OP_PUSH,  1'b1, TS_MAX,  24'h800000,  16'h8000);  // equal stamp joins
        send_op(OP_POP,   1'b0, '0,      '0,          '0);
        send_op(OP_POP,   1'b0, '0,      '0,          '0);
        send_op(OP_POP,   1'b0, '0,      '0,          '0);
        send_op(OP_POP,   1'b0, '0,      '0,          '0);        // empties the queue
        send_op(OP_POP,   1'b0, '0,      '0,          '0);
        send_op(OP_PUSH,  1'b1, '0,      24'h000010,  16'h1234);  // last time kept after emptying
        send_op(OP_CLEAR, 1'b1, TS_MAX,  24'hFFFFFF,  16'hFFFF);
        send_op(OP_PUSH,  1'b1, TS_MIN,  24'h7FFFFF,  16'h5555);  // joins after clear
        send_op(OP_PUSH,  1'b1, TS_MAX,  24'hFFFFFF,  16'hAAAA);  // widest span
        send_op(OP_PUSH,  1'b0, '0,      24'h000100,  16'h0F0F);
        send_op(OP_NONE,  1'b0, '0,      '0,          '0);
        send_op(OP_POP,   1'b0, '0,      '0,          '0);
        send_op(OP_PUSH,  1'b1, TS_MAX,  24'h000002,  16'hF0F0);
        send_op(OP_CLEAR, 1'b0, '0,      '0,          '0);
    endtask

    task automatic test_fill_and_overflow();
        ts_cursor = TS_W'({$urandom(), $urandom()}) >> 2;
        send_op(OP_CLEAR, 1'b0, '0, '0, '0);
        for (int n = 0; n < DEPTH; n++) begin
            ts_cursor = ts_cursor + $urandom_range(0, 100);
            send_op(OP_PUSH, $urandom_range(0, 3) != 0, ts_cursor, SIZE_W'($urandom()),
                    TAG_W'($urandom()));
        end
        // dropped pushes must not move the last in-order time
        send_op(OP_PUSH, 1'b1, TS_MAX, 24'hFFFFFF, 16'hFFFF);
        send_op(OP_PUSH, 1'b1, TS_MIN, 24'h000000, 16'h0000);
        send_op(OP_PUSH, 1'b0, '0,     24'h000001, 16'h0001);
        for (int n = 0; n <= DEPTH; n++)
            send_op(OP_POP, 1'b0, '0, '0, '0);
        send_op(OP_PUSH, 1'b1, ts_cursor + 1, 24'h000040, 16'hBEEF);
        send_op(OP_PUSH, 1'b1, ts_cursor + 9, 24'h000080, 16'hCAFE);
        send_op(OP_POP,  1'b0, '0, '0, '0);
        send_op(OP_POP,  1'b0, '0, '0, '0);
    endtask

    task automatic test_backpressure();
        tx_idle    = 1'b0;
        rx_idle    = 1'b0;
        press_hold = PRESSURE_HOLD;
        for (int n = 0; n < PRESSURE_ITEMS; n++)
            send_random_op(700);
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int push_permille;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // each phase picks filling, balanced or draining traffic at random
            phase_len = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
                0:       push_permille = 850;
                1:       push_permille = 490;
                default: push_permille = 200;
            endcase
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                send_random_op(push_permille);
                sent++;
            end
        end
    endtask

    initial begin
        int drain_wait;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_opcode        = OP_PUSH;
        i_has_timestamp = 1'b0;
        i_timestamp     = '0;
        i_byte_size     = '0;
        i_packet_tag    = '0;
        clear_shadow();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_fill_and_overflow();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_wait = 0;
        while (exp_wr != exp_rd && drain_wait < 20000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        if (exp_wr != exp_rd)
            report_mismatch("results never arrived, count", 64'(exp_wr - exp_rd), 64'(0));
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hdl/tpf_pkg.sv
hdl/tpf_mem.sv
hdl/timestamped_packet_fifo.sv
hdl/tpf_checker.sv
tb/tb_top.sv
